// ===== rtl/bpfs_pkg.sv =====
// ----------------------------------------------------------------------------
// bpfs_pkg
// Shared types and constants for the beacon and poll frame sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package bpfs_pkg;

  // default sizing of the sequencer
  localparam int unsigned NUM_NODES_DEF   = 8;
  localparam int unsigned NUM_BEACONS_DEF = 3;
  localparam int unsigned TIMER_WIDTH_DEF = 24;

  // configuration register widths
  localparam int unsigned MASK_W   = 8;
  localparam int unsigned LONG_W   = 24;
  localparam int unsigned SHORT_W  = 20;
  localparam int unsigned CFG_DW   = 24;
  localparam int unsigned CFG_IW   = 3;

  // beacon and slot index widths
  localparam int unsigned BEACON_W = 2;
  localparam int unsigned SLOT_W   = 4;

  // frame encoding
  localparam logic       KIND_BEACON = 1'b0;
  localparam logic       KIND_POLL   = 1'b1;
  localparam logic [7:0] POLL_CODE   = 8'h40;
  localparam logic [7:0] THIRD_FILL  = 8'h00;
  localparam logic [1:0] LEN_BEACON  = 2'd3;
  localparam logic [1:0] LEN_POLL    = 2'd2;

  // configuration register reset values
  localparam logic [MASK_W-1:0]  RST_POLL_MASK = 8'd0;
  localparam logic [LONG_W-1:0]  RST_STARTUP   = 24'd640;
  localparam logic [SHORT_W-1:0] RST_GUARD     = 20'd64;
  localparam logic [SHORT_W-1:0] RST_SLOT      = 20'd192;
  localparam logic [LONG_W-1:0]  RST_LISTEN    = 24'd1280;
  localparam logic [LONG_W-1:0]  RST_FRAME     = 24'd46080;

  // configuration register indexes
  typedef enum logic [CFG_IW-1:0] {
    CFG_POLL_MASK = 3'd0,
    CFG_STARTUP   = 3'd1,
    CFG_GUARD     = 3'd2,
    CFG_SLOT      = 3'd3,
    CFG_LISTEN    = 3'd4,
    CFG_FRAME     = 3'd5
  } cfg_idx_e;

  // sequencer phases
  typedef enum logic [2:0] {
    PH_STARTUP      = 3'd0,
    PH_BEACON_GUARD = 3'd1,
    PH_LISTEN       = 3'd2,
    PH_SLOT         = 3'd3,
    PH_SLOT_GUARD   = 3'd4,
    PH_FRAME_END    = 3'd5
  } phase_e;

  // configuration register file contents
  typedef struct packed {
    logic [MASK_W-1:0]  poll_mask;
    logic [LONG_W-1:0]  startup_ticks;
    logic [SHORT_W-1:0] guard_ticks;
    logic [SHORT_W-1:0] slot_ticks;
    logic [LONG_W-1:0]  listen_ticks;
    logic [LONG_W-1:0]  frame_ticks;
  } cfg_t;

  // one outgoing frame descriptor
  typedef struct packed {
    logic       frame_kind;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] third_byte;
    logic [1:0] frame_length;
  } frame_t;

endpackage

`default_nettype wire

// ===== rtl/bpfs_tick_if.sv =====
// ----------------------------------------------------------------------------
// bpfs_tick_if
// Valid/ready channel carrying one timer tick flag per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpfs_tick_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

`default_nettype wire

// ===== rtl/bpfs_frame_if.sv =====
// ----------------------------------------------------------------------------
// bpfs_frame_if
// Valid/ready channel carrying one beacon or poll frame descriptor per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpfs_frame_if;
  logic       valid;
  logic       ready;
  logic       frame_kind;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [7:0] third_byte;
  logic [1:0] frame_length;

  modport source (
    output valid, output frame_kind, output first_byte, output second_byte,
    output third_byte, output frame_length, input ready
  );
  modport sink (
    input valid, input frame_kind, input first_byte, input second_byte,
    input third_byte, input frame_length, output ready
  );
endinterface

`default_nettype wire

// ===== rtl/beacon_poll_frame_sequencer.sv =====
// ----------------------------------------------------------------------------
// beacon_poll_frame_sequencer
// Turns timer ticks into beacon and poll frame descriptors per frame schedule.
// ----------------------------------------------------------------------------
//  channel    dir  beat payload                                         
//  tick_i     in   tick                                                 
//  frame_o    out  frame_kind, first_byte, second_byte, third_byte,     
//                  frame_length                                         
//  cfg_*_i    in   write enable, register index, 24-bit write data      
//
// one tick beat is taken per cycle while the buffer has space; its frame, if
// any, is buffered the same edge and offered on frame_o from the next cycle
// a two-entry output buffer holds frames; tick_i stalls only when both are
// full, with no combinational path from frame_o.ready to tick_i.ready
// reset clears the phase machine, timers and buffer; registers take defaults
// ----------------------------------------------------------------------------
`default_nettype none

module beacon_poll_frame_sequencer
  import bpfs_pkg::*;
#(
  parameter int unsigned NUM_NODES   = NUM_NODES_DEF,
  parameter int unsigned NUM_BEACONS = NUM_BEACONS_DEF,
  parameter int unsigned TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  bpfs_tick_if.sink              tick_i,
  bpfs_frame_if.source           frame_o,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_IW-1:0] cfg_idx_i,
  input  wire logic [CFG_DW-1:0] cfg_wdata_i
);

  cfg_t   cfg;
  logic   buf_space;
  logic   step;
  logic   res_valid;
  frame_t res;
  frame_t out_data;

  // configuration registers
  bpfs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // input beat acceptance
  assign tick_i.ready = buf_space;
  assign step         = tick_i.valid && buf_space && tick_i.tick;

  // phase machine
  bpfs_core #(
    .NUM_NODES   (NUM_NODES),
    .NUM_BEACONS (NUM_BEACONS),
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (step),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result buffer
  bpfs_out_buf u_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (buf_space),
    .valid_o     (frame_o.valid),
    .ready_i     (frame_o.ready),
    .data_o      (out_data)
  );

  assign frame_o.frame_kind   = out_data.frame_kind;
  assign frame_o.first_byte   = out_data.first_byte;
  assign frame_o.second_byte  = out_data.second_byte;
  assign frame_o.third_byte   = out_data.third_byte;
  assign frame_o.frame_length = out_data.frame_length;

endmodule

`default_nettype wire

// ===== rtl/bpfs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bpfs_cfg_regs
// Write-only configuration registers; unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfs_cfg_regs
  import bpfs_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_IW-1:0] cfg_idx_i,
  input  wire logic [CFG_DW-1:0] cfg_wdata_i,
  output cfg_t                   cfg_o
);

  cfg_t cfg_q, cfg_d;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_POLL_MASK: cfg_d.poll_mask     = cfg_wdata_i[MASK_W-1:0];
        CFG_STARTUP:   cfg_d.startup_ticks = cfg_wdata_i[LONG_W-1:0];
        CFG_GUARD:     cfg_d.guard_ticks   = cfg_wdata_i[SHORT_W-1:0];
        CFG_SLOT:      cfg_d.slot_ticks    = cfg_wdata_i[SHORT_W-1:0];
        CFG_LISTEN:    cfg_d.listen_ticks  = cfg_wdata_i[LONG_W-1:0];
        CFG_FRAME:     cfg_d.frame_ticks   = cfg_wdata_i[LONG_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poll_mask     <= RST_POLL_MASK;
      cfg_q.startup_ticks <= RST_STARTUP;
      cfg_q.guard_ticks   <= RST_GUARD;
      cfg_q.slot_ticks    <= RST_SLOT;
      cfg_q.listen_ticks  <= RST_LISTEN;
      cfg_q.frame_ticks   <= RST_FRAME;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/bpfs_core.sv =====
// ----------------------------------------------------------------------------
// bpfs_core
// Phase machine with saturating phase and frame timers; one tick per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfs_core
  import bpfs_pkg::*;
#(
  parameter int unsigned NUM_NODES   = NUM_NODES_DEF,
  parameter int unsigned NUM_BEACONS = NUM_BEACONS_DEF,
  parameter int unsigned TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic step_i,
  output logic      res_valid_o,
  output frame_t    res_o
);

  localparam int unsigned TW    = TIMER_WIDTH;
  localparam int unsigned CMP_W = (TW > LONG_W) ? TW : LONG_W;
  localparam logic [TW-1:0]       TMAX       = {TW{1'b1}};
  localparam logic [SLOT_W-1:0]   LAST_SLOT  = SLOT_W'(NUM_NODES);
  localparam logic [BEACON_W:0]   BEACON_CNT = (BEACON_W + 1)'(NUM_BEACONS);

  phase_e              phase_q, phase_d;
  logic [TW-1:0]       phase_cnt_q, phase_cnt_d;
  logic [TW-1:0]       frame_cnt_q, frame_cnt_d;
  logic [BEACON_W-1:0] beacon_q, beacon_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [MASK_W-1:0]   mask_q, mask_d;

  logic [TW-1:0]       phase_inc, frame_inc;
  logic [LONG_W-1:0]   phase_len;
  logic                phase_hit, frame_hit, last_slot;
  logic                go_start, go_beacon, go_slot, go_slot_guard, go_frame_end;
  logic [BEACON_W-1:0] beacon_idx;
  logic [SLOT_W-1:0]   slot_idx;
  logic                more_beacons;

  // saturating timer increments
  assign phase_inc = (phase_cnt_q == TMAX) ? phase_cnt_q : phase_cnt_q + 1'b1;
  assign frame_inc = (phase_q == PH_STARTUP || frame_cnt_q == TMAX) ?
                     frame_cnt_q : frame_cnt_q + 1'b1;

  // wait length of the current phase
  always_comb begin
    case (phase_q)
      PH_STARTUP:      phase_len = cfg_i.startup_ticks;
      PH_BEACON_GUARD: phase_len = LONG_W'(cfg_i.guard_ticks);
      PH_LISTEN:       phase_len = cfg_i.listen_ticks;
      PH_SLOT:         phase_len = LONG_W'(cfg_i.slot_ticks);
      PH_SLOT_GUARD:   phase_len = LONG_W'(cfg_i.guard_ticks);
      default:         phase_len = '0;
    endcase
  end

  // lengths beyond the timer range clamp to the saturated count
  assign phase_hit = (CMP_W'(phase_inc) >= CMP_W'(phase_len)) || (phase_inc == TMAX);
  assign frame_hit = (CMP_W'(frame_inc) >= CMP_W'(cfg_i.frame_ticks)) ||
                     (frame_inc == TMAX);
  assign last_slot = (slot_q >= LAST_SLOT);

  // transition decode
  always_comb begin
    go_start      = 1'b0;
    go_beacon     = 1'b0;
    go_slot       = 1'b0;
    go_slot_guard = 1'b0;
    go_frame_end  = 1'b0;
    if (step_i) begin
      case (phase_q)
        PH_STARTUP:      go_start = phase_hit;
        PH_BEACON_GUARD: go_beacon = phase_hit;
        PH_LISTEN:       go_slot = phase_hit;
        PH_SLOT:         go_slot_guard = phase_hit;
        PH_SLOT_GUARD: begin
          go_slot      = phase_hit && !last_slot;
          go_start     = phase_hit && last_slot && frame_hit;
          go_frame_end = phase_hit && last_slot && !frame_hit;
        end
        PH_FRAME_END:    go_start = frame_hit;
        default:         go_start = 1'b0;
      endcase
    end
  end

  assign beacon_idx   = go_start ? '0 : beacon_q + 1'b1;
  assign more_beacons = ((BEACON_W + 1)'(beacon_idx) + 1'b1) < BEACON_CNT;
  assign slot_idx     = (phase_q == PH_LISTEN) ? SLOT_W'(1) : slot_q + 1'b1;

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (step_i) begin
      if (go_start || go_beacon) begin
        phase_d = more_beacons ? PH_BEACON_GUARD : PH_LISTEN;
      end else if (go_slot) begin
        phase_d = PH_SLOT;
      end else if (go_slot_guard) begin
        phase_d = PH_SLOT_GUARD;
      end else if (go_frame_end) begin
        phase_d = PH_FRAME_END;
      end else begin
        case (phase_q)
          PH_STARTUP, PH_BEACON_GUARD, PH_LISTEN, PH_SLOT, PH_SLOT_GUARD,
          PH_FRAME_END: phase_d = phase_q;
          default:      phase_d = PH_STARTUP;
        endcase
      end
    end
  end

  // timers, indexes and working mask
  always_comb begin
    phase_cnt_d = phase_cnt_q;
    frame_cnt_d = frame_cnt_q;
    beacon_d    = beacon_q;
    slot_d      = slot_q;
    mask_d      = mask_q;
    if (step_i) begin
      frame_cnt_d = go_start ? '0 : frame_inc;
      if (go_start || go_beacon || go_slot || go_slot_guard || go_frame_end ||
          phase_d != phase_q) begin
        phase_cnt_d = '0;
      end else begin
        phase_cnt_d = phase_inc;
      end
      if (go_start) begin
        mask_d   = cfg_i.poll_mask;
        beacon_d = '0;
        slot_d   = '0;
      end
      if (go_beacon) begin
        beacon_d = beacon_idx;
      end
      if (go_slot) begin
        slot_d = slot_idx;
        mask_d = mask_q >> 1;
      end
    end
  end

  // result frame for this tick
  always_comb begin
    res_valid_o       = go_start || go_beacon || (go_slot && mask_q[0]);
    res_o.third_byte  = THIRD_FILL;
    if (go_slot) begin
      res_o.frame_kind   = KIND_POLL;
      res_o.first_byte   = POLL_CODE;
      res_o.second_byte  = 8'(slot_idx);
      res_o.frame_length = LEN_POLL;
    end else begin
      res_o.frame_kind   = KIND_BEACON;
      res_o.first_byte   = 8'(beacon_idx);
      res_o.second_byte  = go_start ? cfg_i.poll_mask : mask_q;
      res_o.frame_length = LEN_BEACON;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_STARTUP;
      phase_cnt_q <= '0;
      frame_cnt_q <= '0;
      beacon_q    <= '0;
      slot_q      <= '0;
      mask_q      <= '0;
    end else begin
      phase_q     <= phase_d;
      phase_cnt_q <= phase_cnt_d;
      frame_cnt_q <= frame_cnt_d;
      beacon_q    <= beacon_d;
      slot_q      <= slot_d;
      mask_q      <= mask_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bpfs_out_buf.sv =====
// ----------------------------------------------------------------------------
// bpfs_out_buf
// Two-entry result buffer; space flag depends on registered state only.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfs_out_buf
  import bpfs_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire frame_t push_data_i,
  output logic        space_o,
  output logic        valid_o,
  input  wire logic   ready_i,
  output frame_t      data_o
);

  frame_t     mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign space_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign pop     = valid_o && ready_i;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    case ({push_i, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_beacon_poll_frame_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_beacon_poll_frame_sequencer
// Self-checking bench for the beacon and poll frame sequencer. Tick beats
// feed an in-bench schedule tracker that queues the frames each tick should
// release. Every frame beat is compared field by field with the oldest queued
// frame. Settings are rewritten between runs of ticks, once the block is idle.
// ----------------------------------------------------------------------------

module tb_beacon_poll_frame_sequencer;
  import bpfs_pkg::*;

  localparam int unsigned CLK_HALF_NS      = 6;
  localparam int unsigned RST_CYCLES       = 3;
  localparam int unsigned SETTLE_CYCLES    = 4;
  localparam int unsigned DRAIN_LIMIT      = 5000;
  localparam int unsigned HOLD_CYCLES      = 400;
  localparam int unsigned TICK_TARGET      = 1950;
  localparam int unsigned RUN_LIMIT_CYCLES = 1_500_000;

  localparam logic [MASK_W-1:0]  MASK_ALL     = '1;
  localparam logic [SHORT_W-1:0] SHORT_MAX    = '1;
  localparam logic [LONG_W-1:0]  LONG_MAX     = '1;
  localparam logic [CFG_IW-1:0]  IDX_SPARE_LO = CFG_IW'(CFG_FRAME + 1);
  localparam logic [CFG_IW-1:0]  IDX_SPARE_HI = '1;

  // tracks the frame schedule and holds the frames still owed by the block
  class frame_schedule;
    cfg_t                       regs;
    phase_e                     phase;
    logic [TIMER_WIDTH_DEF-1:0] phase_cnt;
    logic [TIMER_WIDTH_DEF-1:0] frame_cnt;
    logic [BEACON_W-1:0]        beacon_no;
    logic [SLOT_W-1:0]          slot_no;
    logic [MASK_W-1:0]          live_mask;
    frame_t                     due_frames[$];
    int unsigned                errors;

    function new();
      regs.poll_mask     = RST_POLL_MASK;
      regs.startup_ticks = RST_STARTUP;
      regs.guard_ticks   = RST_GUARD;
      regs.slot_ticks    = RST_SLOT;
      regs.listen_ticks  = RST_LISTEN;
      regs.frame_ticks   = RST_FRAME;
      phase     = PH_STARTUP;
      phase_cnt = '0;
      frame_cnt = '0;
      beacon_no = '0;
      slot_no   = '0;
      live_mask = '0;
      errors    = 0;
    endfunction

    function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
      case (idx)
        CFG_POLL_MASK: regs.poll_mask     = data[MASK_W-1:0];
        CFG_STARTUP:   regs.startup_ticks = data[LONG_W-1:0];
        CFG_GUARD:     regs.guard_ticks   = data[SHORT_W-1:0];
        CFG_SLOT:      regs.slot_ticks    = data[SHORT_W-1:0];
        CFG_LISTEN:    regs.listen_ticks  = data[LONG_W-1:0];
        CFG_FRAME:     regs.frame_ticks   = data[LONG_W-1:0];
        default: ;
      endcase
    endfunction

    // saturating timer step
    function logic [TIMER_WIDTH_DEF-1:0] bump(logic [TIMER_WIDTH_DEF-1:0] v);
      return (&v) ? v : v + 1'b1;
    endfunction

    function bit hit(logic [TIMER_WIDTH_DEF-1:0] cnt, logic [LONG_W-1:0] len);
      return cnt >= len;
    endfunction

    function void queue_frame(logic kind, logic [7:0] b1, logic [7:0] b2,
                              logic [1:0] len);
      frame_t f;
      f.frame_kind   = kind;
      f.first_byte   = b1;
      f.second_byte  = b2;
      f.third_byte   = THIRD_FILL;
      f.frame_length = len;
      due_frames.push_back(f);
    endfunction

    function void send_beacon();
      phase_cnt = '0;
      phase = (beacon_no + 1 < NUM_BEACONS_DEF) ? PH_BEACON_GUARD : PH_LISTEN;
      queue_frame(KIND_BEACON, 8'(beacon_no), live_mask, LEN_BEACON);
    endfunction

    // a frame latches the mask and restarts the beacon and slot walk
    function void open_frame();
      frame_cnt = '0;
      live_mask = regs.poll_mask;
      beacon_no = '0;
      slot_no   = '0;
      send_beacon();
    endfunction

    function void open_slot();
      logic poll;
      poll      = live_mask[0];
      live_mask = live_mask >> 1;
      phase     = PH_SLOT;
      phase_cnt = '0;
      if (poll) queue_frame(KIND_POLL, POLL_CODE, 8'(slot_no), LEN_POLL);
    endfunction

    // advance the schedule by one tick beat
    function void take_tick(logic t);
      if (!t) return;
      if (phase != PH_STARTUP) frame_cnt = bump(frame_cnt);
      phase_cnt = bump(phase_cnt);
      case (phase)
        PH_STARTUP: begin
          if (hit(phase_cnt, regs.startup_ticks)) open_frame();
        end
        PH_BEACON_GUARD: begin
          if (hit(phase_cnt, regs.guard_ticks)) begin
            beacon_no++;
            send_beacon();
          end
        end
        PH_LISTEN: begin
          if (hit(phase_cnt, regs.listen_ticks)) begin
            slot_no = 1;
            open_slot();
          end
        end
        PH_SLOT: begin
          if (hit(phase_cnt, regs.slot_ticks)) begin
            phase     = PH_SLOT_GUARD;
            phase_cnt = '0;
          end
        end
        PH_SLOT_GUARD: begin
          if (hit(phase_cnt, regs.guard_ticks)) begin
            if (slot_no < NUM_NODES_DEF) begin
              slot_no++;
              open_slot();
            end else if (hit(frame_cnt, regs.frame_ticks)) begin
              // overrun: the period is already over when the slots end
              open_frame();
            end else begin
              phase     = PH_FRAME_END;
              phase_cnt = '0;
            end
          end
        end
        PH_FRAME_END: begin
          if (hit(frame_cnt, regs.frame_ticks)) open_frame();
        end
        default: begin
          phase     = PH_STARTUP;
          phase_cnt = '0;
        end
      endcase
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void match_frame(frame_t got);
      frame_t want;
      if (due_frames.size() == 0) begin
        $error("frame beat with none expected: kind %0h first %0h second %0h",
               got.frame_kind, got.first_byte, got.second_byte);
        errors++;
        return;
      end
      want = due_frames.pop_front();
      check_field("frame_kind", want.frame_kind, got.frame_kind);
      check_field("first_byte", want.first_byte, got.first_byte);
      check_field("second_byte", want.second_byte, got.second_byte);
      check_field("third_byte", want.third_byte, got.third_byte);
      check_field("frame_length", want.frame_length, got.frame_length);
    endfunction
  endclass

  logic              clk_i  = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_idx;
  logic [CFG_DW-1:0] cfg_wdata;

  bpfs_tick_if  tick_bus ();
  bpfs_frame_if frame_bus ();

  frame_schedule sched = new();
  frame_t        seen_frame;
  bit            hold_req;
  bit            tick_steady;
  bit            sink_steady;
  int unsigned   tick_count;

  beacon_poll_frame_sequencer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (tick_bus),
    .frame_o     (frame_bus),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // clock
  always begin
    #(CLK_HALF_NS) clk_i = 1'b1;
    #(CLK_HALF_NS) clk_i = 1'b0;
  end

  // beat monitor: predict on tick beats, check frame beats
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (tick_bus.valid && tick_bus.ready) sched.take_tick(tick_bus.tick);
      if (frame_bus.valid && frame_bus.ready) begin
        seen_frame.frame_kind   = frame_bus.frame_kind;
        seen_frame.first_byte   = frame_bus.first_byte;
        seen_frame.second_byte  = frame_bus.second_byte;
        seen_frame.third_byte   = frame_bus.third_byte;
        seen_frame.frame_length = frame_bus.frame_length;
        sched.match_frame(seen_frame);
      end
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // frame sink: random stalls, plus a long hold on request
  initial begin
    int unsigned stall_left;
    int unsigned gap;
    stall_left      = 0;
    frame_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left != 0) begin
        frame_bus.ready <= 1'b0;
        stall_left--;
      end else if (sink_steady) begin
        frame_bus.ready <= 1'b1;
      end else begin
        gap = idle_len();
        if (gap == 0) begin
          frame_bus.ready <= 1'b1;
        end else begin
          frame_bus.ready <= 1'b0;
          stall_left = gap - 1;
        end
      end
    end
  end

  task automatic push_tick(input logic t);
    int unsigned gap;
    gap = tick_steady ? 0 : idle_len();
    @(negedge clk_i);
    if (gap != 0) begin
      tick_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    tick_bus.valid <= 1'b1;
    tick_bus.tick  <= t;
    tick_count++;
    do @(posedge clk_i); while (!tick_bus.ready);
  endtask

  // stop ticking and wait for every owed frame, then let the block settle
  task automatic drain();
    int unsigned waited;
    waited = 0;
    @(negedge clk_i);
    tick_bus.valid <= 1'b0;
    while (sched.due_frames.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    sched.set_reg(idx, data);
  endtask

  task automatic end_writes();
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [LONG_W-1:0] pick_wait(int unsigned top_small,
                                                  logic [LONG_W-1:0] top);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return '0;
    if (roll < 7) return top;
    return LONG_W'($urandom_range(1, top_small));
  endfunction

  // fresh random settings for the next run of ticks
  task automatic program_setup();
    int unsigned       roll;
    logic [MASK_W-1:0] mask;
    roll = $urandom_range(0, 9);
    mask = (roll == 0) ? '0 : (roll == 1) ? MASK_ALL : MASK_W'($urandom());
    write_reg(CFG_POLL_MASK, CFG_DW'(mask));
    write_reg(CFG_STARTUP, pick_wait(50, LONG_MAX));
    write_reg(CFG_GUARD, pick_wait(6, LONG_W'(SHORT_MAX)));
    write_reg(CFG_SLOT, pick_wait(8, LONG_W'(SHORT_MAX)));
    write_reg(CFG_LISTEN, pick_wait(12, LONG_MAX));
    write_reg(CFG_FRAME, pick_wait(120, LONG_MAX));
    if ($urandom_range(0, 5) == 0)
      write_reg(CFG_IW'($urandom_range(IDX_SPARE_LO, IDX_SPARE_HI)), CFG_DW'($urandom()));
    end_writes();
  endtask

  // stimulus
  initial begin
    int unsigned n;
    int unsigned run_len;
    int unsigned pause_at;
    tick_bus.valid = 1'b0;
    tick_bus.tick  = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_POLL_MASK;
    cfg_wdata      = '0;
    hold_req       = 1'b0;
    tick_steady    = 1'b0;
    sink_steady    = 1'b0;
    tick_count     = 0;
    repeat (RST_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // every wait zero and every node polled: full frame, then an overrun
    write_reg(CFG_POLL_MASK, CFG_DW'(MASK_ALL));
    write_reg(CFG_STARTUP, '0);
    write_reg(CFG_GUARD, '0);
    write_reg(CFG_SLOT, '0);
    write_reg(CFG_LISTEN, '0);
    write_reg(CFG_FRAME, '0);
    end_writes();
    for (n = 0; n < 24; n++) push_tick(n % 11 != 5);
    drain();

    // largest waits and writes past the register list
    write_reg(CFG_POLL_MASK, '0);
    write_reg(CFG_STARTUP, LONG_MAX);
    write_reg(CFG_GUARD, CFG_DW'(SHORT_MAX));
    write_reg(CFG_SLOT, CFG_DW'(SHORT_MAX));
    write_reg(CFG_LISTEN, LONG_MAX);
    write_reg(CFG_FRAME, LONG_MAX);
    write_reg(IDX_SPARE_LO, CFG_DW'($urandom()));
    write_reg(IDX_SPARE_HI, CFG_DW'($urandom()));
    end_writes();
    for (n = 0; n < 4; n++) push_tick(1'b1);
    drain();

    // sink holds off while ticks keep coming, then a full pause; startup keeps its largest wait, so no frames come out
    write_reg(CFG_POLL_MASK, CFG_DW'(MASK_ALL));
    write_reg(CFG_GUARD, '0);
    write_reg(CFG_SLOT, '0);
    write_reg(CFG_LISTEN, '0);
    write_reg(CFG_FRAME, '0);
    end_writes();
    tick_steady = 1'b1;
    hold_req    = 1'b1;
    for (n = 0; n < 80; n++) push_tick(1'b1);
    drain();
    for (n = 0; n < 20; n++) push_tick(1'b1);
    drain();
    tick_steady = 1'b0;

    // random settings and tick streams
    while (tick_count < TICK_TARGET) begin
      program_setup();
      tick_steady = ($urandom_range(0, 4) == 0);
      sink_steady = ($urandom_range(0, 4) == 0);
      run_len  = $urandom_range(40, 160);
      pause_at = ($urandom_range(0, 7) == 0) ? run_len / 2 : run_len;
      for (n = 0; n < run_len; n++) begin
        if (n == pause_at) drain();
        push_tick($urandom_range(0, 6) != 0);
      end
      drain();
    end

    if (sched.due_frames.size() != 0) begin
      $error("%0d expected frames never arrived", sched.due_frames.size());
      sched.errors++;
    end
    if (sched.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #(RUN_LIMIT_CYCLES * 2 * CLK_HALF_NS);
    $display("TEST FAILED");
    $finish;
  end

endmodule
